@@ hdl/sdc_pkg.sv @@
// ----------------------------------------------------------------------------
// sdc_pkg
// shared types and fixed constants of the stereo decimator
// ----------------------------------------------------------------------------
`default_nettype none
package sdc_pkg;

   localparam int SAMPLE_W = 9;
   localparam int OUT_W    = 16;
   localparam int RATE_W   = 24;
   localparam int SUM_W    = 32;
   localparam int PHASE_W  = 25;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] REG_INPUT_RATE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_OUTPUT_RATE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_AVERAGE_EN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_HIGHPASS_EN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_LOWPASS_EN  = 3'd4;

   localparam logic [RATE_W-1:0] INPUT_RATE_RST  = 24'd1048576;
   localparam logic [RATE_W-1:0] OUTPUT_RATE_RST = 24'd48000;

   localparam int SAMPLES_PER_UNIT = 240;
   localparam int OUT_SCALE        = 16383;

   // control from the top level to each lane
   typedef struct packed {
      logic start;
      logic take;
      logic highpass_en;
      logic lowpass_en;
   } sdc_ctl_type;

   // status from one lane back to the top level
   typedef struct packed {
      logic idle;
      logic done;
   } sdc_sts_type;

endpackage
`default_nettype wire

@@ hdl/sdc_lane.sv @@
// ----------------------------------------------------------------------------
// sdc_lane
// one channel: serial divider for the average, dc blocker, low-pass, scaling
// ----------------------------------------------------------------------------
`default_nettype none
module sdc_lane #(
   parameter int FRAC_BITS   = 20,
   parameter int COUNT_WIDTH = 16
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  sdc_pkg::sdc_ctl_type                  ctl,
   input  wire [sdc_pkg::SUM_W+FRAC_BITS:0]      numer,
   input  wire [COUNT_WIDTH+7:0]                 denom,
   output sdc_pkg::sdc_sts_type                  sts,
   output logic signed [sdc_pkg::OUT_W-1:0]      result
);
   import sdc_pkg::*;

   localparam int NW  = SUM_W + FRAC_BITS + 1;
   localparam int DW  = COUNT_WIDTH + 8;
   localparam int CW  = $clog2(NW + 1);
   localparam int SW  = FRAC_BITS + 4;
   localparam int YW  = FRAC_BITS + 20;
   localparam int PW  = YW + FRAC_BITS + 16;
   localparam int QW  = PW - FRAC_BITS;

   localparam longint B_VAL = (64'd15734039 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
   localparam longint C_VAL = ((64'd2 << FRAC_BITS) + 64'd2) / 64'd5;
   localparam logic signed [FRAC_BITS:0] B_S = (FRAC_BITS+1)'(B_VAL);
   localparam logic signed [FRAC_BITS:0] C_S = (FRAC_BITS+1)'(C_VAL);
   localparam logic signed [15:0]        K_S = 16'(OUT_SCALE);
   localparam logic signed [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);
   localparam logic signed [PW-1:0] S_HI = {{(PW-SW+1){1'b0}}, {(SW-1){1'b1}}};
   localparam logic signed [PW-1:0] S_LO = {{(PW-SW+1){1'b1}}, {(SW-1){1'b0}}};
   localparam logic signed [QW-1:0] O_HI = QW'(32767);
   localparam logic signed [QW-1:0] O_LO = -QW'(32768);

   typedef enum logic [9:0] {
      S_IDLE    = 10'b0000000001,
      S_DIV     = 10'b0000000010,
      S_HP_MUL  = 10'b0000000100,
      S_HP_ADD  = 10'b0000001000,
      S_HP_SUB  = 10'b0000010000,
      S_LP_MUL  = 10'b0000100000,
      S_LP_ADD  = 10'b0001000000,
      S_OUT_MUL = 10'b0010000000,
      S_OUT_SAT = 10'b0100000000,
      S_DONE    = 10'b1000000000
   } state_type;

   state_type               state_ff, state_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic [DW:0]             rem_ff, rem_in;
   logic [NW-1:0]           quo_ff, quo_in;
   logic [DW-1:0]           den_ff, den_in;
   logic signed [YW-1:0]    y_ff, y_in;
   logic signed [PW-1:0]    prod_ff, prod_in;
   logic signed [SW-1:0]    dc_ff, dc_in;
   logic signed [SW-1:0]    sm_ff, sm_in;
   logic signed [OUT_W-1:0] res_ff, res_in;

   logic [DW:0]             rem_sh;
   logic [DW:0]             rem_sub;
   logic signed [YW:0]      hp_diff;
   logic signed [YW:0]      lp_diff;
   logic signed [YW+FRAC_BITS+1:0] hp_prod;
   logic signed [YW+FRAC_BITS+1:0] lp_prod;
   logic signed [YW+15:0]   out_prod;
   logic signed [PW-1:0]    rnd_val;
   logic signed [PW-1:0]    acc_val;
   logic signed [SW-1:0]    acc_sat;
   logic signed [PW-1:0]    neg_prod;
   logic signed [QW-1:0]    q_val;

   always_comb begin
      rem_sh   = {rem_ff[DW-1:0], quo_ff[NW-1]};
      rem_sub  = rem_sh - {1'b0, den_ff};
      hp_diff  = (YW+1)'(y_ff) - (YW+1)'(dc_ff);
      lp_diff  = (YW+1)'(sm_ff) - (YW+1)'(y_ff);
      hp_prod  = hp_diff * B_S;
      lp_prod  = lp_diff * C_S;
      out_prod = y_ff * K_S;
      rnd_val  = (prod_ff + HALF) >>> FRAC_BITS;
      if (state_ff == S_HP_ADD) begin
         acc_val = PW'(dc_ff) + rnd_val;
      end else begin
         acc_val = PW'(y_ff) + rnd_val;
      end
      if (acc_val > S_HI) begin
         acc_sat = SW'(S_HI);
      end else if (acc_val < S_LO) begin
         acc_sat = SW'(S_LO);
      end else begin
         acc_sat = SW'(acc_val);
      end
      // truncate toward zero
      neg_prod = -prod_ff;
      if (prod_ff[PW-1]) begin
         q_val = -QW'(neg_prod >>> FRAC_BITS);
      end else begin
         q_val = QW'(prod_ff >>> FRAC_BITS);
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      den_in   = den_ff;
      y_in     = y_ff;
      prod_in  = prod_ff;
      dc_in    = dc_ff;
      sm_in    = sm_ff;
      res_in   = res_ff;
      case (state_ff)
         S_IDLE: begin
            if (ctl.start) begin
               quo_in   = numer;
               den_in   = denom;
               rem_in   = '0;
               cnt_in   = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (rem_sub[DW]) begin
               rem_in = rem_sh;
               quo_in = {quo_ff[NW-2:0], 1'b0};
            end else begin
               rem_in = rem_sub;
               quo_in = {quo_ff[NW-2:0], 1'b1};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(NW - 1)) begin
               state_in = S_HP_MUL;
            end
         end
         S_HP_MUL: begin
            y_in    = $signed(quo_ff[YW-1:0]);
            prod_in = PW'(hp_diff * B_S);
            if (ctl.highpass_en) begin
               prod_in  = PW'(($signed((YW+1)'($signed(quo_ff[YW-1:0]))) -
                                (YW+1)'(dc_ff)) * B_S);
               state_in = S_HP_ADD;
            end else begin
               state_in = S_LP_MUL;
            end
         end
         S_HP_ADD: begin
            dc_in    = acc_sat;
            state_in = S_HP_SUB;
         end
         S_HP_SUB: begin
            y_in     = y_ff - YW'(dc_ff);
            state_in = S_LP_MUL;
         end
         S_LP_MUL: begin
            prod_in = PW'(lp_prod);
            if (ctl.lowpass_en) begin
               state_in = S_LP_ADD;
            end else begin
               state_in = S_OUT_MUL;
            end
         end
         S_LP_ADD: begin
            sm_in    = acc_sat;
            y_in     = YW'(acc_sat);
            state_in = S_OUT_MUL;
         end
         S_OUT_MUL: begin
            prod_in  = PW'(out_prod);
            state_in = S_OUT_SAT;
         end
         S_OUT_SAT: begin
            if (q_val > O_HI) begin
               res_in = 16'sh7fff;
            end else if (q_val < O_LO) begin
               res_in = -16'sh8000;
            end else begin
               res_in = OUT_W'(q_val);
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (ctl.take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         dc_ff    <= '0;
         sm_ff    <= '0;
      end else begin
         state_ff <= state_in;
         dc_ff    <= dc_in;
         sm_ff    <= sm_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      den_ff  <= den_in;
      y_ff    <= y_in;
      prod_ff <= prod_in;
      res_ff  <= res_in;
   end

   assign sts.idle = (state_ff == S_IDLE);
   assign sts.done = (state_ff == S_DONE);
   assign result   = res_ff;

endmodule
`default_nettype wire

@@ hdl/stereo_decimator_dc_block_lowpass.sv @@
// ----------------------------------------------------------------------------
// stereo_decimator_dc_block_lowpass
// boxcar decimator with dc blocker and one-pole low-pass, one lane per channel
// ----------------------------------------------------------------------------
// an item that emits no output is taken whenever both lanes are idle
// an emitting item runs the serial divider and then the filter states in its
// lane, and the next item is taken only once both lanes are idle again
// the result is registered: a waiting output does not block the next item
// synchronous active-high reset clears all filter and decimator state and
// loads the register defaults
`default_nettype none
module stereo_decimator_dc_block_lowpass #(
   parameter int FRAC_BITS   = 20,
   parameter int COUNT_WIDTH = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [23:0] req_tdata,   // left_sample[8:0], right_sample[17:9]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [31:0] rsp_tdata,   // left_out[15:0], right_out[31:16]
   input  wire         csr_we,
   input  wire  [sdc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire  [sdc_pkg::RATE_W-1:0]    csr_wdata
);
   import sdc_pkg::*;

   localparam int NW = SUM_W + FRAC_BITS + 1;
   localparam int DW = COUNT_WIDTH + 8;

   logic [RATE_W-1:0]      irate_ff, orate_ff;
   logic                   avg_en_ff, hp_en_ff, lp_en_ff;
   logic [PHASE_W-1:0]     phase_ff, phase_in;
   logic [SUM_W-1:0]       lsum_ff, lsum_in, rsum_ff, rsum_in;
   logic [COUNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [31:0]            rsp_data_ff, rsp_data_in;

   logic [SAMPLE_W-1:0]    lsamp, rsamp;
   logic [SUM_W:0]         lsum_add, rsum_add;
   logic [PHASE_W-1:0]     phase_add;
   logic                   accept, emit, merge;
   logic [DW-1:0]          den;
   logic [NW-1:0]          lnum, rnum;

   sdc_ctl_type            ctl;
   sdc_sts_type            lsts, rsts;
   logic signed [OUT_W-1:0] lres, rres;

   assign lsamp      = req_tdata[SAMPLE_W-1:0];
   assign rsamp      = req_tdata[2*SAMPLE_W-1:SAMPLE_W];
   assign req_tready = lsts.idle & rsts.idle;
   assign accept     = req_tvalid & req_tready;

   always_comb begin
      lsum_add  = {1'b0, lsum_ff} + (SUM_W+1)'(lsamp);
      rsum_add  = {1'b0, rsum_ff} + (SUM_W+1)'(rsamp);
      lsum_in   = lsum_add[SUM_W] ? '1 : lsum_add[SUM_W-1:0];
      rsum_in   = rsum_add[SUM_W] ? '1 : rsum_add[SUM_W-1:0];
      cnt_in    = (cnt_ff == '1) ? cnt_ff : cnt_ff + 1'b1;
      phase_add = phase_ff + PHASE_W'(orate_ff);
      emit      = phase_add >= PHASE_W'(irate_ff);
      phase_in  = emit ? phase_add - PHASE_W'(irate_ff) : phase_add;
      if (avg_en_ff) begin
         den  = DW'(cnt_in) * DW'(SAMPLES_PER_UNIT);
         lnum = (NW'(lsum_in) << FRAC_BITS) + NW'(den >> 1);
         rnum = (NW'(rsum_in) << FRAC_BITS) + NW'(den >> 1);
      end else begin
         den  = DW'(SAMPLES_PER_UNIT);
         lnum = (NW'(lsamp) << FRAC_BITS) + NW'(SAMPLES_PER_UNIT / 2);
         rnum = (NW'(rsamp) << FRAC_BITS) + NW'(SAMPLES_PER_UNIT / 2);
      end
   end

   // merge both lanes into the output register
   assign merge = lsts.done & rsts.done & (~rsp_valid_ff | rsp_tready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (merge) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {rres, lres};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign ctl.start       = accept & emit;
   assign ctl.take        = merge;
   assign ctl.highpass_en = hp_en_ff;
   assign ctl.lowpass_en  = lp_en_ff;

   sdc_lane #(.FRAC_BITS(FRAC_BITS), .COUNT_WIDTH(COUNT_WIDTH)) u_lane_left (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .numer  (lnum),
      .denom  (den),
      .sts    (lsts),
      .result (lres)
   );

   sdc_lane #(.FRAC_BITS(FRAC_BITS), .COUNT_WIDTH(COUNT_WIDTH)) u_lane_right (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .numer  (rnum),
      .denom  (den),
      .sts    (rsts),
      .result (rres)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         irate_ff     <= INPUT_RATE_RST;
         orate_ff     <= OUTPUT_RATE_RST;
         avg_en_ff    <= 1'b1;
         hp_en_ff     <= 1'b1;
         lp_en_ff     <= 1'b1;
         phase_ff     <= '0;
         lsum_ff      <= '0;
         rsum_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_INPUT_RATE:  irate_ff  <= csr_wdata;
               REG_OUTPUT_RATE: orate_ff  <= csr_wdata;
               REG_AVERAGE_EN:  avg_en_ff <= csr_wdata[0];
               REG_HIGHPASS_EN: hp_en_ff  <= csr_wdata[0];
               REG_LOWPASS_EN:  lp_en_ff  <= csr_wdata[0];
               default: begin
               end
            endcase
         end
         if (accept) begin
            phase_ff <= phase_in;
            if (emit) begin
               lsum_ff <= '0;
               rsum_ff <= '0;
               cnt_ff  <= '0;
            end else begin
               lsum_ff <= lsum_in;
               rsum_ff <= rsum_in;
               cnt_ff  <= cnt_in;
            end
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire
